@@ sv/mktd_pkg.sv @@
// ----------------------------------------------------------------------------
// mktd_pkg: shared types, constants and the Morse lookup for the key decoder
// Holds the event and report payload structs, the mode and register codes,
// the reset values of the configuration registers and the code decoder.
// ----------------------------------------------------------------------------
package mktd_pkg;

  // Default sizes handed to the top level
  localparam int DEF_MAX_CODE = 6;
  localparam int DEF_MAX_TEXT = 64;

  // Longest code the lookup knows
  localparam int TABLE_CODE_LEN = 6;

  // Event kinds
  localparam logic [1:0] MODE_RELEASE   = 2'd0;
  localparam logic [1:0] MODE_TICK      = 2'd1;
  localparam logic [1:0] MODE_BACKSPACE = 2'd2;
  localparam logic [1:0] MODE_CLEAR     = 2'd3;

  // Release outcomes
  localparam logic [1:0] RR_NONE    = 2'd0;
  localparam logic [1:0] RR_IGNORED = 2'd1;
  localparam logic [1:0] RR_SYMBOL  = 2'd2;
  localparam logic [1:0] RR_CONTROL = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_HOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH     = 3'd4;

  // Configuration reset values
  localparam logic [15:0] RST_DASH_THRESHOLD = 16'd200;
  localparam logic [15:0] RST_LETTER_GAP     = 16'd600;
  localparam logic [15:0] RST_WORD_GAP       = 16'd1400;
  localparam logic [15:0] RST_CONTROL_HOLD   = 16'd1500;
  localparam logic [6:0]  RST_MAX_LENGTH     = 7'd64;

  localparam logic [6:0] ASCII_SPACE = 7'h20;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] held_ms;
    logic [31:0] time_ms;
    logic        button_pressed;
  } evt_t;

  typedef struct packed {
    logic [1:0] release_result;
    logic       changed;
    logic [6:0] letter_char;
    logic       space_added;
    logic       char_removed;
    logic [6:0] text_length;
    logic [2:0] code_length;
    logic [6:0] preview_char;
    logic       invalid_code;
    logic       text_full;
  } rpt_t;

  // Code lookup. Bit i of bits is symbol i, a one is a dash. Only the first
  // cnt symbols take part; an empty, overlong or unknown code gives zero.
  function automatic logic [6:0] decode_code(logic [7:0] bits, logic [3:0] cnt);
    logic [5:0] mask;
    logic [5:0] pat;
    logic [6:0] ch;
    mask = 6'((7'd1 << cnt) - 7'd1);
    pat  = bits[5:0] & mask;
    ch   = 7'd0;
    if (cnt != 4'd0 && cnt <= 4'(TABLE_CODE_LEN)) begin
      unique case ({cnt[2:0], pat})
        {3'd2, 6'b000010}: ch = 7'h41; // A
        {3'd4, 6'b000001}: ch = 7'h42; // B
        {3'd4, 6'b000101}: ch = 7'h43; // C
        {3'd3, 6'b000001}: ch = 7'h44; // D
        {3'd1, 6'b000000}: ch = 7'h45; // E
        {3'd4, 6'b000100}: ch = 7'h46; // F
        {3'd3, 6'b000011}: ch = 7'h47; // G
        {3'd4, 6'b000000}: ch = 7'h48; // H
        {3'd2, 6'b000000}: ch = 7'h49; // I
        {3'd4, 6'b001110}: ch = 7'h4A; // J
        {3'd3, 6'b000101}: ch = 7'h4B; // K
        {3'd4, 6'b000010}: ch = 7'h4C; // L
        {3'd2, 6'b000011}: ch = 7'h4D; // M
        {3'd2, 6'b000001}: ch = 7'h4E; // N
        {3'd3, 6'b000111}: ch = 7'h4F; // O
        {3'd4, 6'b000110}: ch = 7'h50; // P
        {3'd4, 6'b001011}: ch = 7'h51; // Q
        {3'd3, 6'b000010}: ch = 7'h52; // R
        {3'd3, 6'b000000}: ch = 7'h53; // S
        {3'd1, 6'b000001}: ch = 7'h54; // T
        {3'd3, 6'b000100}: ch = 7'h55; // U
        {3'd4, 6'b001000}: ch = 7'h56; // V
        {3'd3, 6'b000110}: ch = 7'h57; // W
        {3'd4, 6'b001001}: ch = 7'h58; // X
        {3'd4, 6'b001101}: ch = 7'h59; // Y
        {3'd4, 6'b000011}: ch = 7'h5A; // Z
        {3'd5, 6'b011111}: ch = 7'h30; // 0
        {3'd5, 6'b011110}: ch = 7'h31; // 1
        {3'd5, 6'b011100}: ch = 7'h32; // 2
        {3'd5, 6'b011000}: ch = 7'h33; // 3
        {3'd5, 6'b010000}: ch = 7'h34; // 4
        {3'd5, 6'b000000}: ch = 7'h35; // 5
        {3'd5, 6'b000001}: ch = 7'h36; // 6
        {3'd5, 6'b000011}: ch = 7'h37; // 7
        {3'd5, 6'b000111}: ch = 7'h38; // 8
        {3'd5, 6'b001111}: ch = 7'h39; // 9
        {3'd6, 6'b101010}: ch = 7'h2E; // period
        {3'd6, 6'b110011}: ch = 7'h2C; // comma
        {3'd6, 6'b001100}: ch = 7'h3F; // question mark
        {3'd6, 6'b110101}: ch = 7'h21; // exclamation mark
        {3'd6, 6'b011110}: ch = 7'h27; // apostrophe
        {3'd5, 6'b001001}: ch = 7'h2F; // slash
        {3'd6, 6'b100001}: ch = 7'h2D; // hyphen
        {3'd5, 6'b001101}: ch = 7'h28; // open paren
        {3'd6, 6'b101101}: ch = 7'h29; // close paren
        {3'd6, 6'b000111}: ch = 7'h3A; // colon
        {3'd6, 6'b010110}: ch = 7'h40; // at sign
        default:           ch = 7'd0;
      endcase
    end
    return ch;
  endfunction

endpackage

@@ sv/mktd_ram.sv @@
// ----------------------------------------------------------------------------
// mktd_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mktd_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/mktd_rpt_queue.sv @@
// ----------------------------------------------------------------------------
// mktd_rpt_queue: two-entry report queue
// Decouples the decoder from the report receiver so a new event can be taken
// while an earlier report is still waiting.
// ----------------------------------------------------------------------------
module mktd_rpt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mktd_pkg::rpt_t push_data,
  output logic          full,
  output logic          rpt_valid,
  input  logic          rpt_stall,
  output mktd_pkg::rpt_t rpt
);
  import mktd_pkg::*;

  rpt_t       slot0;
  rpt_t       slot1;
  logic [1:0] count;
  logic       pop;
  logic       push_head;

  assign pop       = (count != 2'd0) && !rpt_stall;
  assign full      = (count == 2'd2);
  assign rpt_valid = (count != 2'd0);
  assign rpt       = slot0;

  // New entry lands at the head when the queue is empty or drains this cycle
  assign push_head = (count == 2'd0) || (count == 2'd1 && pop);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Slots: head in slot0, push never arrives while full
  always_ff @(posedge clk) begin
    if (push && push_head) begin
      slot0 <= push_data;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && !push_head) begin
      slot1 <= push_data;
    end
  end

endmodule

@@ sv/morse_key_timing_decoder_top.sv @@
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_top: Morse key timing decoder
// Turns key events (release, tick, backspace, clear) into a text store and
// reports one result per event.
// ----------------------------------------------------------------------------
// Usage:
//   evt channel (evt_valid / evt_stall / evt) carries one key event per
//   transaction. rpt channel (rpt_valid / rpt_stall / rpt) returns exactly one
//   report per event, in order. cfg channel (cfg_valid / cfg_ready) writes the
//   timing registers and the text limit; cfg_ready is always high and writes
//   belong only to idle periods.
//   Each report is registered in the report queue before it shows on rpt.
//   Throughput: one event per cycle while evt_stall is low. A backspace
//   that deletes a text character stalls for the text RAM read-back of the
//   new last character, and an event that appends both a letter and a word
//   space stalls for its second write (the RAM has a single write port).
//   Stall: reports queue in a two-entry buffer; evt_stall rises while both
//   entries are occupied and stays up until the receiver drains one.
//   Reset: clears the pending code, text count, gap tracking, flags and the
//   queue, and restores register defaults. Text RAM contents are not cleared;
//   no entry is read before it is written.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_top #(
  parameter int MAX_CODE = mktd_pkg::DEF_MAX_CODE,
  parameter int MAX_TEXT = mktd_pkg::DEF_MAX_TEXT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              evt_valid,
  output logic                              evt_stall,
  input  mktd_pkg::evt_t                    evt,
  output logic                              rpt_valid,
  input  logic                              rpt_stall,
  output mktd_pkg::rpt_t                    rpt,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mktd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);
  import mktd_pkg::*;

  localparam int CCW = $clog2(MAX_CODE + 1);
  localparam int CW  = $clog2(MAX_TEXT + 1);
  localparam int AW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int LW  = (CW > 7) ? CW : 7;

  // Configuration registers
  logic [15:0] dash_threshold;
  logic [15:0] letter_gap;
  logic [15:0] word_gap;
  logic [15:0] control_hold;
  logic [6:0]  max_length;

  // Decoder state
  logic [MAX_CODE-1:0] code_bits;
  logic [CCW-1:0]      code_count;
  logic [CW-1:0]       text_count;
  logic [31:0]         last_release_time;
  logic                gap_armed;
  logic                letter_done;
  logic                word_done;
  logic                invalid_flag;
  logic                full_flag;
  logic                last_space;

  // Sequencing around the text RAM
  logic          rd_wait;
  logic          rd_fresh;
  logic          wr_pend;
  logic [AW-1:0] pend_addr;
  logic [6:0]    pend_data;

  logic          accept;
  logic          q_full;
  logic [6:0]    rd_data;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [6:0]    ram_wr_data;
  logic [LW-1:0] limit;
  logic          last_is_space;

  // Next-state values
  logic [MAX_CODE-1:0] code_bits_next;
  logic [CCW-1:0]      code_count_next;
  logic [CW-1:0]       text_count_next;
  logic [31:0]         last_release_time_next;
  logic                gap_armed_next;
  logic                letter_done_next;
  logic                word_done_next;
  logic                invalid_flag_next;
  logic                full_flag_next;
  logic                last_space_next;
  logic                w1_en;
  logic [AW-1:0]       w1_addr;
  logic [6:0]          w1_data;
  logic                w2_en;
  logic [AW-1:0]       w2_addr;
  logic [6:0]          w2_data;
  rpt_t                rpt_next;

  assign cfg_ready = 1'b1;
  assign evt_stall = q_full | rd_wait | wr_pend;
  assign accept    = evt_valid & ~evt_stall;

  // Effective text limit
  always_comb begin
    if (max_length == 7'd0) begin
      limit = LW'(1);
    end else if (LW'(max_length) > LW'(MAX_TEXT)) begin
      limit = LW'(MAX_TEXT);
    end else begin
      limit = LW'(max_length);
    end
  end

  // Last character is a space: from RAM right after a deleting backspace
  assign last_is_space = rd_fresh ? (rd_data == ASCII_SPACE) : last_space;

  // Event processing
  always_comb begin
    logic        gap_en;
    logic [31:0] gap_at;
    logic [31:0] elapsed;
    logic        gap_changed;
    logic [6:0]  ch;
    logic [1:0]  rr;
    logic        changed;
    logic        removed;
    logic [6:0]  letter;
    logic        space;

    code_bits_next         = code_bits;
    code_count_next        = code_count;
    text_count_next        = text_count;
    last_release_time_next = last_release_time;
    gap_armed_next         = gap_armed;
    letter_done_next       = letter_done;
    word_done_next         = word_done;
    invalid_flag_next      = invalid_flag;
    full_flag_next         = full_flag;
    last_space_next        = last_is_space;
    w1_en   = 1'b0;
    w1_addr = '0;
    w1_data = '0;
    w2_en   = 1'b0;
    w2_addr = '0;
    w2_data = '0;
    rr      = RR_NONE;
    changed = 1'b0;
    removed = 1'b0;
    letter  = 7'd0;
    space   = 1'b0;
    gap_changed = 1'b0;
    ch      = 7'd0;

    // Gap check: on a release at press time, on an idle tick at tick time
    gap_en  = ((evt.mode == MODE_RELEASE) && (evt.held_ms != 32'd0)) ||
              ((evt.mode == MODE_TICK) && !evt.button_pressed);
    gap_at  = (evt.mode == MODE_RELEASE) ? (evt.time_ms - evt.held_ms) : evt.time_ms;
    elapsed = gap_at - last_release_time;

    if (gap_en && gap_armed) begin
      // Letter gap commits the pending code
      if (!letter_done && elapsed >= 32'(letter_gap)) begin
        if (code_count_next != '0) begin
          gap_changed = 1'b1;
          ch = decode_code(8'(code_bits_next), 4'(code_count_next));
          code_bits_next  = '0;
          code_count_next = '0;
          if (ch == 7'd0) begin
            invalid_flag_next = 1'b1;
          end else if (LW'(text_count_next) >= limit) begin
            full_flag_next = 1'b1;
          end else begin
            w1_en   = 1'b1;
            w1_addr = AW'(text_count_next);
            w1_data = ch;
            text_count_next   = text_count_next + CW'(1);
            invalid_flag_next = 1'b0;
            full_flag_next    = 1'b0;
            letter            = ch;
            last_space_next   = 1'b0;
          end
        end
        letter_done_next = 1'b1;
      end
      // Word gap appends one space unless the text is empty, full or ends in a space
      if (!word_done && elapsed >= 32'(word_gap)) begin
        invalid_flag_next = 1'b0;
        if (text_count_next != '0 && !last_space_next) begin
          if (LW'(text_count_next) >= limit) begin
            full_flag_next = 1'b1;
          end else begin
            if (!w1_en) begin
              w1_en   = 1'b1;
              w1_addr = AW'(text_count_next);
              w1_data = ASCII_SPACE;
            end else begin
              w2_en   = 1'b1;
              w2_addr = AW'(text_count_next);
              w2_data = ASCII_SPACE;
            end
            text_count_next = text_count_next + CW'(1);
            full_flag_next  = 1'b0;
            space           = 1'b1;
            last_space_next = 1'b1;
            gap_changed     = 1'b1;
          end
        end
        word_done_next = 1'b1;
      end
    end

    unique case (evt.mode)
      MODE_RELEASE: begin
        if (evt.held_ms == 32'd0) begin
          rr = RR_IGNORED;
        end else if (evt.held_ms >= 32'(control_hold)) begin
          // Control hold: commit whatever is pending, disarm gaps
          if (code_count_next != '0) begin
            ch = decode_code(8'(code_bits_next), 4'(code_count_next));
            code_bits_next  = '0;
            code_count_next = '0;
            if (ch == 7'd0) begin
              invalid_flag_next = 1'b1;
            end else if (LW'(text_count_next) >= limit) begin
              full_flag_next = 1'b1;
            end else begin
              if (!w1_en) begin
                w1_en   = 1'b1;
                w1_addr = AW'(text_count_next);
                w1_data = ch;
              end else begin
                w2_en   = 1'b1;
                w2_addr = AW'(text_count_next);
                w2_data = ch;
              end
              text_count_next   = text_count_next + CW'(1);
              invalid_flag_next = 1'b0;
              full_flag_next    = 1'b0;
              letter            = ch;
              last_space_next   = 1'b0;
            end
          end
          gap_armed_next   = 1'b0;
          letter_done_next = 1'b0;
          word_done_next   = 1'b0;
          rr = RR_CONTROL;
        end else if (code_count_next >= CCW'(MAX_CODE)) begin
          invalid_flag_next = 1'b1;
          rr = RR_IGNORED;
        end else begin
          // Dot or dash
          if (evt.held_ms >= 32'(dash_threshold)) begin
            code_bits_next = code_bits_next | (MAX_CODE'(1) << code_count_next);
          end
          code_count_next        = code_count_next + CCW'(1);
          last_release_time_next = evt.time_ms;
          gap_armed_next         = 1'b1;
          letter_done_next       = 1'b0;
          word_done_next         = 1'b0;
          invalid_flag_next      = 1'b0;
          full_flag_next         = 1'b0;
          rr = RR_SYMBOL;
        end
      end
      MODE_TICK: begin
        changed = gap_changed;
      end
      MODE_BACKSPACE: begin
        invalid_flag_next = 1'b0;
        full_flag_next    = 1'b0;
        if (code_count != '0) begin
          code_count_next = code_count - CCW'(1);
          code_bits_next  = code_bits & ~(MAX_CODE'(1) << code_count_next);
          changed = 1'b1;
        end else if (text_count != '0) begin
          text_count_next = text_count - CW'(1);
          changed = 1'b1;
          removed = 1'b1;
        end
      end
      MODE_CLEAR: begin
        changed = (text_count != '0) || (code_count != '0);
        text_count_next   = '0;
        code_bits_next    = '0;
        code_count_next   = '0;
        invalid_flag_next = 1'b0;
        full_flag_next    = 1'b0;
        gap_armed_next    = 1'b0;
        letter_done_next  = 1'b0;
        word_done_next    = 1'b0;
      end
      default: begin
        changed = 1'b0;
      end
    endcase

    rpt_next.release_result = rr;
    rpt_next.changed        = changed;
    rpt_next.letter_char    = letter;
    rpt_next.space_added    = space;
    rpt_next.char_removed   = removed;
    rpt_next.text_length    = 7'(text_count_next);
    rpt_next.code_length    = 3'(code_count_next);
    rpt_next.preview_char   = decode_code(8'(code_bits_next), 4'(code_count_next));
    rpt_next.invalid_code   = invalid_flag_next;
    rpt_next.text_full      = full_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dash_threshold <= RST_DASH_THRESHOLD;
      letter_gap     <= RST_LETTER_GAP;
      word_gap       <= RST_WORD_GAP;
      control_hold   <= RST_CONTROL_HOLD;
      max_length     <= RST_MAX_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DASH_THRESHOLD: dash_threshold <= cfg_data;
        REG_LETTER_GAP:     letter_gap     <= cfg_data;
        REG_WORD_GAP:       word_gap       <= cfg_data;
        REG_CONTROL_HOLD:   control_hold   <= cfg_data;
        REG_MAX_LENGTH:     max_length     <= cfg_data[6:0];
        default:            max_length     <= max_length;
      endcase
    end
  end

  // Decoder state and RAM sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits         <= '0;
      code_count        <= '0;
      text_count        <= '0;
      last_release_time <= '0;
      gap_armed         <= 1'b0;
      letter_done       <= 1'b0;
      word_done         <= 1'b0;
      invalid_flag      <= 1'b0;
      full_flag         <= 1'b0;
      last_space        <= 1'b0;
      rd_wait           <= 1'b0;
      rd_fresh          <= 1'b0;
      wr_pend           <= 1'b0;
    end else begin
      // Read-back lands in the cycle after the count moved
      if (rd_wait) begin
        rd_wait  <= 1'b0;
        rd_fresh <= 1'b1;
      end
      if (wr_pend) begin
        wr_pend <= 1'b0;
      end
      if (accept) begin
        code_bits         <= code_bits_next;
        code_count        <= code_count_next;
        text_count        <= text_count_next;
        last_release_time <= last_release_time_next;
        gap_armed         <= gap_armed_next;
        letter_done       <= letter_done_next;
        word_done         <= word_done_next;
        invalid_flag      <= invalid_flag_next;
        full_flag         <= full_flag_next;
        last_space        <= last_space_next;
        rd_fresh          <= 1'b0;
        rd_wait           <= rpt_next.char_removed;
        wr_pend           <= w2_en;
      end
    end
  end

  // Second write of a transaction is registered and issued in the next cycle
  always_ff @(posedge clk) begin
    if (accept && w2_en) begin
      pend_addr <= w2_addr;
      pend_data <= w2_data;
    end
  end

  assign ram_wr_en   = wr_pend | (accept & w1_en);
  assign ram_wr_addr = wr_pend ? pend_addr : w1_addr;
  assign ram_wr_data = wr_pend ? pend_data : w1_data;

  mktd_ram #(
    .WIDTH (7),
    .DEPTH (MAX_TEXT)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (AW'(text_count - CW'(1))),
    .rd_data (rd_data)
  );

  mktd_rpt_queue u_rpt_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (rpt_next),
    .full      (q_full),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt)
  );

  // Checks
  a_one_hazard: assert property (@(posedge clk) disable iff (rst)
    !(rd_wait && wr_pend))
    else $error("read-back and pending write overlap");

  a_readback_order: assert property (@(posedge clk) disable iff (rst)
    rd_wait |=> (rd_fresh && !rd_wait))
    else $error("read-back did not complete in one cycle");

  a_text_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(text_count) <= 32'(MAX_TEXT)) && (32'(code_count) <= 32'(MAX_CODE)))
    else $error("text or code count out of range");

  a_pend_write_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && w2_en) |=> (wr_pend && evt_stall))
    else $error("second write not held off the event channel");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: Morse key timing decoder
// Drives key events (releases, ticks, backspaces, clears) into the decoder
// and checks every report against an in-bench prediction of the code, text
// and flag state. Directed cases cover the register and field extremes;
// random keying then sends well-formed letters and words mixed with noise,
// under several sender and receiver idling profiles and one long stall.
// ----------------------------------------------------------------------------
module testbench;
  import mktd_pkg::*;

  localparam int MAX_SYMBOLS  = DEF_MAX_CODE;
  localparam int TEXT_DEPTH   = DEF_MAX_TEXT;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 20_000_000;
  localparam int PHASE_ITEMS  = 330;

  logic        clk;
  logic        rst;
  logic        evt_valid;
  logic        evt_stall;
  evt_t        evt;
  logic        rpt_valid;
  logic        rpt_stall;
  rpt_t        rpt;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  // Idling profile and long-stall requests
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_requests = 0;

  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  rpt_t        pending_reports[$];
  rpt_t        next_report;

  // Morse table: length, symbol bits (1 = dash, symbol 0 in bit 0), character
  int          pat_len[47];
  logic [5:0]  pat_bits[47];
  logic [6:0]  pat_chr[47];
  int          pat_count = 0;

  // Predicted register copies
  logic [15:0] thr_dash   = RST_DASH_THRESHOLD;
  logic [15:0] gap_letter = RST_LETTER_GAP;
  logic [15:0] gap_word   = RST_WORD_GAP;
  logic [15:0] thr_ctrl   = RST_CONTROL_HOLD;
  logic [6:0]  len_limit  = RST_MAX_LENGTH;

  // Predicted decoder state
  logic [5:0]  code_bits = '0;
  int          code_cnt = 0;
  logic [6:0]  text_buf[TEXT_DEPTH];
  int          text_cnt = 0;
  logic [31:0] last_release = '0;
  bit          gap_armed = 0;
  bit          letter_done = 0;
  bit          word_done = 0;
  bit          bad_code = 0;
  bit          store_full = 0;
  logic [6:0]  step_letter;
  bit          step_space;

  // Stimulus time base in milliseconds, wraps at 2^32
  logic [31:0] now_ms = '0;

  morse_key_timing_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Morse table
  // --------------------------------------------------------------------------
  function automatic void add_code(string p, byte c);
    logic [5:0] b;
    b = '0;
    for (int i = 0; i < p.len(); i++) if (p[i] == "-") b[i] = 1'b1;
    pat_len[pat_count]  = p.len();
    pat_bits[pat_count] = b;
    pat_chr[pat_count]  = c[6:0];
    pat_count++;
  endfunction

  initial begin
    add_code(".-", "A");     add_code("-...", "B");   add_code("-.-.", "C");
    add_code("-..", "D");    add_code(".", "E");      add_code("..-.", "F");
    add_code("--.", "G");    add_code("....", "H");   add_code("..", "I");
    add_code(".---", "J");   add_code("-.-", "K");    add_code(".-..", "L");
    add_code("--", "M");     add_code("-.", "N");     add_code("---", "O");
    add_code(".--.", "P");   add_code("--.-", "Q");   add_code(".-.", "R");
    add_code("...", "S");    add_code("-", "T");      add_code("..-", "U");
    add_code("...-", "V");   add_code(".--", "W");    add_code("-..-", "X");
    add_code("-.--", "Y");   add_code("--..", "Z");   add_code("-----", "0");
    add_code(".----", "1");  add_code("..---", "2");  add_code("...--", "3");
    add_code("....-", "4");  add_code(".....", "5");  add_code("-....", "6");
    add_code("--...", "7");  add_code("---..", "8");  add_code("----.", "9");
    add_code(".-.-.-", "."); add_code("--..--", ","); add_code("..--..", "?");
    add_code("-.-.--", "!"); add_code(".----.", "'"); add_code("-..-.", "/");
    add_code("-....-", "-"); add_code("-.--.", "(");  add_code("-.--.-", ")");
    add_code("---...", ":"); add_code(".--.-.", "@");
  end

  // --------------------------------------------------------------------------
  // Decoder prediction
  // --------------------------------------------------------------------------
  function automatic logic [6:0] decode_symbols(logic [5:0] bits, int cnt);
    logic [5:0] mask;
    mask = 6'((1 << cnt) - 1);
    for (int e = 0; e < pat_count; e++)
      if (cnt != 0 && pat_len[e] == cnt && pat_bits[e] == (bits & mask)) return pat_chr[e];
    return 7'd0;
  endfunction

  // Effective text limit: zero acts as one, capped at the store depth
  function automatic int text_cap();
    if (len_limit == 0) return 1;
    if (len_limit > TEXT_DEPTH) return TEXT_DEPTH;
    return len_limit;
  endfunction

  function automatic void push_letter(logic [6:0] ch);
    if (ch == 0) begin
      bad_code = 1'b1;
      return;
    end
    if (text_cnt >= text_cap()) begin
      store_full = 1'b1;
      return;
    end
    text_buf[text_cnt] = ch;
    text_cnt++;
    bad_code    = 1'b0;
    store_full  = 1'b0;
    step_letter = ch;
  endfunction

  // No space at the start of the text or after another space
  function automatic bit push_space();
    bad_code = 1'b0;
    if (text_cnt == 0) return 1'b0;
    if (text_buf[text_cnt - 1] == ASCII_SPACE) return 1'b0;
    if (text_cnt >= text_cap()) begin
      store_full = 1'b1;
      return 1'b0;
    end
    text_buf[text_cnt] = ASCII_SPACE;
    text_cnt++;
    store_full = 1'b0;
    step_space = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit flush_code();
    logic [6:0] ch;
    if (code_cnt == 0) return 1'b0;
    ch = decode_symbols(code_bits, code_cnt);
    code_bits = '0;
    code_cnt  = 0;
    push_letter(ch);
    return 1'b1;
  endfunction

  // Letter and word gaps, measured with a wrapping 32-bit difference
  function automatic bit check_gaps(logic [31:0] at);
    logic [31:0] elapsed;
    bit          touched;
    touched = 1'b0;
    if (!gap_armed) return 1'b0;
    elapsed = at - last_release;
    if (!letter_done && elapsed >= gap_letter) begin
      if (flush_code()) touched = 1'b1;
      letter_done = 1'b1;
    end
    if (!word_done && elapsed >= gap_word) begin
      if (push_space()) touched = 1'b1;
      word_done = 1'b1;
    end
    return touched;
  endfunction

  function automatic rpt_t report_for_event(evt_t ev);
    rpt_t       r;
    logic [1:0] outcome;
    bit         touched;
    bit         dropped;
    outcome     = RR_NONE;
    touched     = 1'b0;
    dropped     = 1'b0;
    step_letter = '0;
    step_space  = 1'b0;
    case (ev.mode)
      MODE_RELEASE: begin
        if (ev.held_ms == 0) begin
          outcome = RR_IGNORED;
        end else begin
          // gaps are judged at the press time of this symbol
          void'(check_gaps(ev.time_ms - ev.held_ms));
          if (ev.held_ms >= thr_ctrl) begin
            void'(flush_code());
            gap_armed   = 1'b0;
            letter_done = 1'b0;
            word_done   = 1'b0;
            outcome     = RR_CONTROL;
          end else if (code_cnt >= MAX_SYMBOLS) begin
            bad_code = 1'b1;
            outcome  = RR_IGNORED;
          end else begin
            if (ev.held_ms >= thr_dash) code_bits[code_cnt] = 1'b1;
            code_cnt++;
            last_release = ev.time_ms;
            gap_armed    = 1'b1;
            letter_done  = 1'b0;
            word_done    = 1'b0;
            bad_code     = 1'b0;
            store_full   = 1'b0;
            outcome      = RR_SYMBOL;
          end
        end
      end
      MODE_TICK: begin
        if (!ev.button_pressed) touched = check_gaps(ev.time_ms);
      end
      MODE_BACKSPACE: begin
        bad_code   = 1'b0;
        store_full = 1'b0;
        if (code_cnt != 0) begin
          code_cnt--;
          code_bits[code_cnt] = 1'b0;
          touched = 1'b1;
        end else if (text_cnt != 0) begin
          text_cnt--;
          touched = 1'b1;
          dropped = 1'b1;
        end
      end
      default: begin
        touched     = (text_cnt != 0) || (code_cnt != 0);
        text_cnt    = 0;
        code_bits   = '0;
        code_cnt    = 0;
        bad_code    = 1'b0;
        store_full  = 1'b0;
        gap_armed   = 1'b0;
        letter_done = 1'b0;
        word_done   = 1'b0;
      end
    endcase
    r.release_result = outcome;
    r.changed        = touched;
    r.letter_char    = step_letter;
    r.space_added    = step_space;
    r.char_removed   = dropped;
    r.text_length    = 7'(text_cnt);
    r.code_length    = 3'(code_cnt);
    r.preview_char   = decode_symbols(code_bits, code_cnt);
    r.invalid_code   = bad_code;
    r.text_full      = store_full;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Report checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rpt_valid && !rpt_stall) begin
      if (pending_reports.size() == 0) begin
        $error("report transaction with no event outstanding: %h", rpt);
        mismatches++;
      end else begin
        next_report = pending_reports.pop_front();
        check_field("release_result", next_report.release_result, rpt.release_result);
        check_field("changed", next_report.changed, rpt.changed);
        check_field("letter_char", next_report.letter_char, rpt.letter_char);
        check_field("space_added", next_report.space_added, rpt.space_added);
        check_field("char_removed", next_report.char_removed, rpt.char_removed);
        check_field("text_length", next_report.text_length, rpt.text_length);
        check_field("code_length", next_report.code_length, rpt.code_length);
        check_field("preview_char", next_report.preview_char, rpt.preview_char);
        check_field("invalid_code", next_report.invalid_code, rpt.invalid_code);
        check_field("text_full", next_report.text_full, rpt.text_full);
      end
    end
  end

  // Receiver stall: random profile, or a long hold-off when one is requested
  initial begin : rpt_stall_gen
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    rpt_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rpt_stall <= 1'b1;
      end else begin
        rpt_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Event and register transactions
  // --------------------------------------------------------------------------
  task automatic send_event(input logic [1:0] mode, input logic [31:0] held,
                            input logic [31:0] at, input bit pressed);
    evt_t item;
    item.mode           = mode;
    item.held_ms        = held;
    item.time_ms        = at;
    item.button_pressed = pressed;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      evt_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    evt_valid <= 1'b1;
    evt       <= item;
    do @(posedge clk); while (evt_stall);
    pending_reports.insert(pending_reports.size(), report_for_event(item));
    sent_count++;
  endtask

  // Sender pauses until every report is back, then the block settles
  task automatic wait_reports_done();
    evt_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only called while the decoder is idle
  task automatic load_timing(input logic [15:0] dash, input logic [15:0] letter,
                             input logic [15:0] word, input logic [15:0] ctrl,
                             input logic [15:0] limit);
    write_reg(REG_DASH_THRESHOLD, dash);
    write_reg(REG_LETTER_GAP, letter);
    write_reg(REG_WORD_GAP, word);
    write_reg(REG_CONTROL_HOLD, ctrl);
    write_reg(REG_MAX_LENGTH, limit);
    cfg_valid  <= 1'b0;
    thr_dash   = dash;
    gap_letter = letter;
    gap_word   = word;
    thr_ctrl   = ctrl;
    len_limit  = limit[6:0];
  endtask

  // --------------------------------------------------------------------------
  // Keying helpers
  // --------------------------------------------------------------------------
  function automatic int range_pick(int lo, int hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  task automatic release_key(input logic [31:0] quiet, input logic [31:0] hold);
    now_ms = now_ms + quiet + hold;
    send_event(MODE_RELEASE, hold, now_ms, $urandom_range(1));
  endtask

  task automatic pass_time(input logic [31:0] ms, input bit pressed);
    now_ms = now_ms + ms;
    send_event(MODE_TICK, $urandom, now_ms, pressed);
  endtask

  // One symbol with an inter-symbol gap shorter than the letter gap
  task automatic key_symbol(input bit dash);
    int quiet;
    int hold;
    int top;
    quiet = range_pick(0, int'(gap_letter) - 1);
    if (dash) begin
      top = int'(thr_ctrl) - 1;
      if (top > int'(thr_dash) + 300) top = int'(thr_dash) + 300;
      hold = range_pick(int'(thr_dash), top);
    end else begin
      hold = range_pick(1, int'(thr_dash) - 1);
    end
    release_key(quiet, hold);
  endtask

  // A whole letter, then the letter gap and optionally a word gap
  task automatic key_char(input int idx, input bit word_end);
    logic [31:0] longest;
    for (int i = 0; i < pat_len[idx]; i++) key_symbol(pat_bits[idx][i]);
    if ($urandom_range(3) == 0)
      send_event(MODE_TICK, $urandom, now_ms + gap_letter + 32'd1, 1'b1);
    longest = (gap_word > gap_letter) ? gap_word : gap_letter;
    if (word_end && $urandom_range(1)) begin
      // letter and space land on the same tick
      pass_time(longest + $urandom_range(30), 1'b0);
    end else begin
      pass_time(gap_letter + $urandom_range(30), 1'b0);
      if (word_end) pass_time(gap_word + $urandom_range(30), 1'b0);
    end
  endtask

  task automatic random_keying(input int unsigned count);
    int unsigned stop_at;
    int          pick;
    logic [31:0] hold;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        key_char($urandom_range(46), $urandom_range(3) == 0);
      end else if (pick < 66) begin
        // holds around the thresholds, zero and full-range values
        case ($urandom_range(5))
          0: hold = $urandom;
          1: hold = thr_dash;
          2: hold = thr_dash - 16'd1;
          3: hold = thr_ctrl;
          4: hold = thr_ctrl - 16'd1;
          default: hold = '0;
        endcase
        release_key($urandom_range(2 * int'(gap_word)), hold);
      end else if (pick < 72) begin
        if ($urandom_range(1)) pass_time($urandom, $urandom_range(1));
        else pass_time($urandom_range(2 * int'(gap_word)), $urandom_range(1));
      end else if (pick < 78) begin
        send_event(MODE_BACKSPACE, $urandom, $urandom, $urandom_range(1));
      end else if (pick < 80) begin
        send_event(MODE_CLEAR, $urandom, $urandom, $urandom_range(1));
      end else if (pick < 84) begin
        release_key($urandom_range(int'(gap_letter)), thr_ctrl + $urandom_range(200));
      end else if (pick < 88) begin
        // one symbol more than the code can hold
        repeat (MAX_SYMBOLS + 1) key_symbol($urandom_range(1));
        pass_time(gap_letter + $urandom_range(30), 1'b0);
      end else if (pick < 95) begin
        // random symbol strings, many of them not in the table
        repeat ($urandom_range(MAX_SYMBOLS, 1)) key_symbol($urandom_range(1));
        pass_time(gap_letter + $urandom_range(30), 1'b0);
      end else begin
        pass_time($urandom_range(2 * int'(gap_word)), 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values, time base just below the wrap point
  task automatic test_keying_basics();
    now_ms = 32'hFFFF_FE00;
    send_event(MODE_RELEASE, 32'd0, now_ms, 1'b1);   // zero hold is ignored
    release_key(32'd50, 32'd100);                    // dot
    send_event(MODE_TICK, 32'hFFFF_FFFF, now_ms + 32'd5000, 1'b1);
    pass_time(32'd600, 1'b0);                        // letter gap exactly, wraps
    pass_time(32'd800, 1'b0);                        // word gap exactly
    release_key(32'd100, 32'd200);                   // dash at the threshold
    release_key(32'd100, 32'hFFFF_FFFF);             // longest hold: control
    repeat (MAX_SYMBOLS + 1) release_key(32'd10, 32'd20);
    pass_time(32'd600, 1'b0);                        // six dots: unknown code
    release_key(32'd10, 32'd300);
    send_event(MODE_BACKSPACE, 32'd0, 32'd0, 1'b0);  // drops the pending symbol
    send_event(MODE_BACKSPACE, 32'd0, 32'd0, 1'b0);  // drops a text character
    send_event(MODE_CLEAR, 32'd0, 32'd0, 1'b0);
    wait_reports_done();
  endtask

  task automatic test_register_extremes();
    // zero threshold and gaps, limit zero acts as one
    load_timing(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    release_key(32'd5, 32'd1);
    pass_time(32'd0, 1'b0);
    release_key(32'd0, 32'd1);
    pass_time(32'd0, 1'b0);
    release_key(32'd0, 32'h0000_FFFF);
    wait_reports_done();
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd127);
    release_key(32'd0, 32'd1);
    wait_reports_done();
  endtask

  // Limit dropped below the current text length
  task automatic test_text_limit();
    load_timing(RST_DASH_THRESHOLD, RST_LETTER_GAP, RST_WORD_GAP, RST_CONTROL_HOLD, 16'd64);
    release_key(32'd10, 32'd50);
    pass_time(32'd700, 1'b0);
    release_key(32'd10, 32'd400);
    pass_time(32'd700, 1'b0);
    wait_reports_done();
    load_timing(RST_DASH_THRESHOLD, RST_LETTER_GAP, RST_WORD_GAP, RST_CONTROL_HOLD, 16'd1);
    release_key(32'd10, 32'd50);
    pass_time(32'd700, 1'b0);
    send_event(MODE_BACKSPACE, 32'd0, 32'd0, 1'b0);
    wait_reports_done();
  endtask

  task automatic test_random_keying(input int unsigned src_pct, input int unsigned sink_pct);
    int dash;
    int letter;
    int word;
    int ctrl;
    int limit;
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
    dash   = $urandom_range(500, 1);
    letter = $urandom_range(1500, 1);
    word   = ($urandom_range(5) == 0) ? $urandom_range(letter, 1)
                                      : letter + $urandom_range(2000, 1);
    ctrl   = dash + $urandom_range(3000, 1);
    case ($urandom_range(7))
      0:       limit = 0;
      1:       limit = $urandom_range(127, 65);
      2:       limit = $urandom_range(4, 1);
      default: limit = $urandom_range(64, 5);
    endcase
    // bits above the 7-bit field are dropped by the register
    if ($urandom_range(3) == 0) limit = limit | ($urandom_range(511, 1) << 7);
    load_timing(16'(dash), 16'(letter), 16'(word), 16'(ctrl), 16'(limit));
    now_ms = $urandom;
    random_keying(PHASE_ITEMS);
    wait_reports_done();
  endtask

  // Receiver holds off while the sender keeps offering events
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    random_keying(24);
    wait_reports_done();
  endtask

  initial begin
    rst       <= 1'b1;
    evt_valid <= 1'b0;
    evt       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_keying_basics();
    test_register_extremes();
    test_text_limit();
    test_random_keying(0, 0);
    test_random_keying(73, 0);
    test_random_keying(0, 73);
    test_random_keying(16, 16);
    test_backpressure();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
sv/mktd_pkg.sv
sv/mktd_ram.sv
sv/mktd_rpt_queue.sv
sv/morse_key_timing_decoder_top.sv
tb/sv/testbench.sv
